// ===== rtl/core/triangle_circumcircle_macros.svh =====
// Assertion macros shared by the circumcircle RTL.
`ifndef TRIANGLE_CIRCUMCIRCLE_MACROS_SVH
`define TRIANGLE_CIRCUMCIRCLE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define TC_ASSERT_IMP(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define TC_ASSERT_NXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/core/tc_pkg.sv =====
// Types and constants of the circumcircle datapath.
package tc_pkg;

    localparam int unsigned CW  = 32;   // coordinate width
    localparam int unsigned OW  = 33;   // vertex offset width
    localparam int unsigned PW  = 66;   // offset product width
    localparam int unsigned DW  = 68;   // doubled determinant width
    localparam int unsigned BW  = 66;   // squared edge length width
    localparam int unsigned HW  = 33;   // half of a squared length
    localparam int unsigned XW  = 67;   // partial product width
    localparam int unsigned NXW = 102;  // numerator width
    localparam int unsigned NW  = 104;  // divider remainder width
    localparam int unsigned QW  = 35;   // quotient bits
    localparam int unsigned MQW = 34;   // clamped quotient magnitude
    localparam int unsigned UW  = 35;   // signed center offset
    localparam int unsigned SW  = 68;   // sum of squares
    localparam int unsigned RW  = 34;   // root bits

    localparam int unsigned DIV_CELLS  = QW;
    localparam int unsigned SQRT_CELLS = RW;

    localparam logic [MQW-1:0] UCLAMP = MQW'(1) << 33;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by_coord;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } t_tri_in;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic [CW-1:0]        radius;
        logic                 degenerate;
        logic                 overflow;
    } t_tri_out;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic                 negx;
        logic                 negy;
        logic                 hix;
        logic                 hiy;
        logic                 deg;
    } t_div_side;

    typedef struct packed {
        logic            valid;
        logic [NW-1:0]   remx;
        logic [NW-1:0]   remy;
        logic [NW-1:0]   den;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
        t_div_side       side;
    } t_div_stage;

    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic                 ovf;
        logic                 deg;
    } t_sq_side;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] rem;
        logic [RW-1:0] root;
        t_sq_side      side;
    } t_sq_stage;

endpackage

// ===== rtl/core/tc_if.sv =====
// Valid/ready channel interfaces for triangles in and circles out.
interface tc_in_if;
    logic             valid;
    logic             ready;
    tc_pkg::t_tri_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tc_out_if;
    logic             valid;
    logic             ready;
    tc_pkg::t_tri_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tc_div_cell.sv =====
// One restoring divider cell: decides one quotient bit for both lanes.
`include "triangle_circumcircle_macros.svh"

module tc_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tc_pkg::t_div_stage i_stage,
    output tc_pkg::t_div_stage o_stage
);

    tc_pkg::t_div_stage r_stage;
    tc_pkg::t_div_stage n_stage;
    logic [tc_pkg::NW-1:0] w_dsh;
    logic [tc_pkg::NW-1:0] w_odsh;

    always_comb begin
        w_dsh   = i_stage.den << SHIFT;
        n_stage = i_stage;
        if (i_stage.remx >= w_dsh) begin
            n_stage.remx      = i_stage.remx - w_dsh;
            n_stage.qx[SHIFT] = 1'b1;
        end
        if (i_stage.remy >= w_dsh) begin
            n_stage.remy      = i_stage.remy - w_dsh;
            n_stage.qy[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
    assign w_odsh  = r_stage.den << SHIFT;

    // remainder stays below the divisor at this weight unless the quotient was too big or the item is degenerate
    `TC_ASSERT_IMP(a_remx_bound, r_stage.valid && !r_stage.side.hix && !r_stage.side.deg, r_stage.remx < w_odsh, "x remainder out of range")
    `TC_ASSERT_IMP(a_remy_bound, r_stage.valid && !r_stage.side.hiy && !r_stage.side.deg, r_stage.remy < w_odsh, "y remainder out of range")

endmodule

// ===== rtl/core/tc_sqrt_cell.sv =====
// One square root cell: decides one root bit by trial subtraction.
`include "triangle_circumcircle_macros.svh"

module tc_sqrt_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tc_pkg::t_sq_stage i_stage,
    output tc_pkg::t_sq_stage o_stage
);

    localparam int unsigned TW = tc_pkg::SW + 2;

    tc_pkg::t_sq_stage r_stage;
    tc_pkg::t_sq_stage n_stage;
    logic [TW-1:0] w_trial;
    logic [TW-1:0] w_bound;

    // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
    always_comb begin
        w_trial = ({{(TW-tc_pkg::RW){1'b0}}, i_stage.root} << (SHIFT + 1))
                | ({{(TW-1){1'b0}}, 1'b1} << (2 * SHIFT));
        n_stage = i_stage;
        if ({{(TW-tc_pkg::SW){1'b0}}, i_stage.rem} >= w_trial) begin
            n_stage.rem         = i_stage.rem - w_trial[tc_pkg::SW-1:0];
            n_stage.root[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
    assign w_bound = (({{(TW-tc_pkg::RW){1'b0}}, r_stage.root} << (SHIFT + 1))
                   | ({{(TW-1){1'b0}}, 1'b1} << (2 * SHIFT)));

    `TC_ASSERT_IMP(a_rem_bound, r_stage.valid, {{(TW-tc_pkg::SW){1'b0}}, r_stage.rem} < w_bound, "root remainder too large")

endmodule

// ===== rtl/core/triangle_circumcircle.sv =====
// Circumcircle center and radius of a triangle, fully pipelined.
//
// Usage:
//  - i_tri carries one triangle per item: vertices A, B, C as signed Q16.16.
//  - o_circ carries one circle per item: center_x, center_y (signed Q16.16,
//    saturated), radius (unsigned Q16.16, saturated), degenerate, overflow.
//  - Collinear or repeated vertices give degenerate = 1 and all else zero.
//  - Throughput: one triangle per cycle while o_circ is not stalled. The pipe
//    has 80 register stages from i_tri to o_circ.valid, among them the divider
//    chain (35 cells, one quotient bit each) and the square root chain
//    (34 cells, one root bit each).
//  - Front end: 7 stages (offsets, products, determinant and squared lengths,
//    partial products, numerators, quotient setup, range check); 3 stages
//    between the chains (clamp, saturate and square, sum).
//  - Every stage advances together whenever the output register is empty or
//    being taken; a stall on o_circ holds the whole pipe, and i_tri.ready drops
//    with it. No item is dropped or repeated.
//  - Synchronous active-low reset clears every valid bit; the pipe is empty
//    and ready on the first cycle after reset. No state ties items together.
`include "triangle_circumcircle_macros.svh"

module triangle_circumcircle (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tc_in_if.sink      i_tri,
    tc_out_if.source   o_circ
);

    localparam int unsigned CW  = tc_pkg::CW;
    localparam int unsigned OW  = tc_pkg::OW;
    localparam int unsigned PW  = tc_pkg::PW;
    localparam int unsigned DW  = tc_pkg::DW;
    localparam int unsigned BW  = tc_pkg::BW;
    localparam int unsigned HW  = tc_pkg::HW;
    localparam int unsigned XW  = tc_pkg::XW;
    localparam int unsigned NXW = tc_pkg::NXW;
    localparam int unsigned NW  = tc_pkg::NW;
    localparam int unsigned QW  = tc_pkg::QW;
    localparam int unsigned MQW = tc_pkg::MQW;
    localparam int unsigned UW  = tc_pkg::UW;
    localparam int unsigned SW  = tc_pkg::SW;
    localparam int unsigned RW  = tc_pkg::RW;

    function automatic logic [NXW-1:0] ext_part(input logic [XW-1:0] v);
        return {{(NXW-XW){v[XW-1]}}, v};
    endfunction

    logic w_en;

    // ---------------- stage 1: offsets from A
    logic                 r_s1_valid;
    logic signed [CW-1:0] r_s1_ax, r_s1_ay;
    logic signed [OW-1:0] r_s1_bxd, r_s1_byd, r_s1_cxd, r_s1_cyd;
    logic signed [OW-1:0] n_s1_bxd, n_s1_byd, n_s1_cxd, n_s1_cyd;

    // ---------------- stage 2: offset products
    logic                 r_s2_valid;
    logic signed [CW-1:0] r_s2_ax, r_s2_ay;
    logic signed [OW-1:0] r_s2_bxd, r_s2_byd, r_s2_cxd, r_s2_cyd;
    logic signed [PW-1:0] r_s2_p, r_s2_q, r_s2_bxsq, r_s2_bysq, r_s2_cxsq, r_s2_cysq;

    // ---------------- stage 3: determinant and squared lengths
    logic                 r_s3_valid;
    logic signed [CW-1:0] r_s3_ax, r_s3_ay;
    logic signed [OW-1:0] r_s3_bxd, r_s3_byd, r_s3_cxd, r_s3_cyd;
    logic signed [DW-1:0] r_s3_d, n_s3_d;
    logic [BW-1:0]        r_s3_b2, r_s3_c2;
    logic signed [PW:0]   w_s3_diff;

    // ---------------- stage 4: partial products of the numerators
    logic                 r_s4_valid;
    logic signed [CW-1:0] r_s4_ax, r_s4_ay;
    logic signed [DW-1:0] r_s4_d;
    logic signed [XW-1:0] r_s4_xa_lo, r_s4_xa_hi, r_s4_xb_lo, r_s4_xb_hi;
    logic signed [XW-1:0] r_s4_ya_lo, r_s4_ya_hi, r_s4_yb_lo, r_s4_yb_hi;
    logic signed [HW:0]   w_s4_b2_lo, w_s4_b2_hi, w_s4_c2_lo, w_s4_c2_hi;

    // ---------------- stage 5: numerators
    logic                  r_s5_valid;
    logic signed [CW-1:0]  r_s5_ax, r_s5_ay;
    logic signed [DW-1:0]  r_s5_d;
    logic [NXW-1:0]        r_s5_nx, r_s5_ny, n_s5_nx, n_s5_ny;

    // ---------------- stage 6: magnitudes for the divider
    logic                 r_s6_valid;
    logic signed [CW-1:0] r_s6_ax, r_s6_ay;
    logic [NW-1:0]        r_s6_numx, r_s6_numy, r_s6_den;
    logic [NW-1:0]        n_s6_numx, n_s6_numy, n_s6_den;
    logic                 r_s6_negx, r_s6_negy, r_s6_deg;
    logic [NXW-1:0]       w_s6_absx, w_s6_absy;
    logic [DW-1:0]        w_s6_absd;

    // ---------------- stage 7: quotient range check, divider entry
    tc_pkg::t_div_stage r_s7, n_s7;
    tc_pkg::t_div_stage w_div [0:tc_pkg::DIV_CELLS];

    // ---------------- post-divider stages
    logic                 r_pa_valid;
    logic signed [CW-1:0] r_pa_ax, r_pa_ay;
    logic [MQW-1:0]       r_pa_mqx, r_pa_mqy, n_pa_mqx, n_pa_mqy;
    logic signed [UW-1:0] r_pa_ux, r_pa_uy;
    logic                 r_pa_deg;

    logic                 r_pb_valid;
    logic signed [CW-1:0] r_pb_ox, r_pb_oy, n_pb_ox, n_pb_oy;
    logic                 r_pb_ovf, n_pb_ovf, r_pb_deg;
    logic [SW-1:0]        r_pb_sqx, r_pb_sqy;
    logic signed [CW+3:0] w_pb_sx, w_pb_sy;

    tc_pkg::t_sq_stage r_pc, n_pc;
    tc_pkg::t_sq_stage w_sq [0:tc_pkg::SQRT_CELLS];

    // ---------------- output register
    logic              r_out_valid;
    tc_pkg::t_tri_out  r_out, n_out;
    tc_pkg::t_sq_stage w_last;
    logic              w_up;
    logic [RW:0]       w_rnd;

    // Global pipe advance: output slot free or being taken.
    assign w_en        = !r_out_valid || o_circ.ready;
    assign i_tri.ready = w_en;

    // ================= stage 1
    always_comb begin
        n_s1_bxd = {i_tri.data.bx[CW-1], i_tri.data.bx}
                 - {i_tri.data.ax[CW-1], i_tri.data.ax};
        n_s1_byd = {i_tri.data.by_coord[CW-1], i_tri.data.by_coord}
                 - {i_tri.data.ay[CW-1], i_tri.data.ay};
        n_s1_cxd = {i_tri.data.cx[CW-1], i_tri.data.cx}
                 - {i_tri.data.ax[CW-1], i_tri.data.ax};
        n_s1_cyd = {i_tri.data.cy[CW-1], i_tri.data.cy}
                 - {i_tri.data.ay[CW-1], i_tri.data.ay};
    end

    // ================= stage 3 and 4 helpers
    assign w_s3_diff  = {r_s2_p[PW-1], r_s2_p} - {r_s2_q[PW-1], r_s2_q};
    assign n_s3_d     = {w_s3_diff, 1'b0};
    assign w_s4_b2_lo = $signed({1'b0, r_s3_b2[HW-1:0]});
    assign w_s4_b2_hi = $signed({1'b0, r_s3_b2[BW-1:HW]});
    assign w_s4_c2_lo = $signed({1'b0, r_s3_c2[HW-1:0]});
    assign w_s4_c2_hi = $signed({1'b0, r_s3_c2[BW-1:HW]});

    // ================= stage 5: nx = cy*|b|^2 - by*|c|^2, ny = bx*|c|^2 - cx*|b|^2
    always_comb begin
        n_s5_nx = (ext_part(r_s4_xa_hi) << HW) + ext_part(r_s4_xa_lo)
                - (ext_part(r_s4_xb_hi) << HW) - ext_part(r_s4_xb_lo);
        n_s5_ny = (ext_part(r_s4_ya_hi) << HW) + ext_part(r_s4_ya_lo)
                - (ext_part(r_s4_yb_hi) << HW) - ext_part(r_s4_yb_lo);
    end

    // ================= stage 6: round(n/d) = floor((2|n| + |d|) / 2|d|)
    always_comb begin
        w_s6_absx = r_s5_nx[NXW-1] ? (~r_s5_nx + 1'b1) : r_s5_nx;
        w_s6_absy = r_s5_ny[NXW-1] ? (~r_s5_ny + 1'b1) : r_s5_ny;
        w_s6_absd = r_s5_d[DW-1] ? DW'(-r_s5_d) : DW'(r_s5_d);
        n_s6_numx = ({{(NW-NXW){1'b0}}, w_s6_absx} << 1) + {{(NW-DW){1'b0}}, w_s6_absd};
        n_s6_numy = ({{(NW-NXW){1'b0}}, w_s6_absy} << 1) + {{(NW-DW){1'b0}}, w_s6_absd};
        n_s6_den  = {{(NW-DW){1'b0}}, w_s6_absd} << 1;
    end

    // ================= stage 7: flag quotients of 2^35 or more
    always_comb begin
        n_s7          = '0;
        n_s7.valid    = r_s6_valid;
        n_s7.remx     = r_s6_numx;
        n_s7.remy     = r_s6_numy;
        n_s7.den      = r_s6_den;
        n_s7.side.ax  = r_s6_ax;
        n_s7.side.ay  = r_s6_ay;
        n_s7.side.negx = r_s6_negx;
        n_s7.side.negy = r_s6_negy;
        n_s7.side.hix = r_s6_numx >= (r_s6_den << QW);
        n_s7.side.hiy = r_s6_numy >= (r_s6_den << QW);
        n_s7.side.deg = r_s6_deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7.valid <= 1'b0;
            r_pa_valid <= 1'b0;
            r_pb_valid <= 1'b0;
            r_pc.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_tri.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7       <= n_s7;
            r_pa_valid <= w_div[tc_pkg::DIV_CELLS].valid;
            r_pb_valid <= r_pa_valid;
            r_pc       <= n_pc;
            r_out_valid <= w_last.valid;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ax  <= i_tri.data.ax;
            r_s1_ay  <= i_tri.data.ay;
            r_s1_bxd <= n_s1_bxd;
            r_s1_byd <= n_s1_byd;
            r_s1_cxd <= n_s1_cxd;
            r_s1_cyd <= n_s1_cyd;

            r_s2_ax   <= r_s1_ax;
            r_s2_ay   <= r_s1_ay;
            r_s2_bxd  <= r_s1_bxd;
            r_s2_byd  <= r_s1_byd;
            r_s2_cxd  <= r_s1_cxd;
            r_s2_cyd  <= r_s1_cyd;
            r_s2_p    <= r_s1_bxd * r_s1_cyd;
            r_s2_q    <= r_s1_byd * r_s1_cxd;
            r_s2_bxsq <= r_s1_bxd * r_s1_bxd;
            r_s2_bysq <= r_s1_byd * r_s1_byd;
            r_s2_cxsq <= r_s1_cxd * r_s1_cxd;
            r_s2_cysq <= r_s1_cyd * r_s1_cyd;

            r_s3_ax  <= r_s2_ax;
            r_s3_ay  <= r_s2_ay;
            r_s3_bxd <= r_s2_bxd;
            r_s3_byd <= r_s2_byd;
            r_s3_cxd <= r_s2_cxd;
            r_s3_cyd <= r_s2_cyd;
            r_s3_d   <= n_s3_d;
            r_s3_b2  <= $unsigned(r_s2_bxsq) + $unsigned(r_s2_bysq);
            r_s3_c2  <= $unsigned(r_s2_cxsq) + $unsigned(r_s2_cysq);

            r_s4_ax    <= r_s3_ax;
            r_s4_ay    <= r_s3_ay;
            r_s4_d     <= r_s3_d;
            r_s4_xa_lo <= r_s3_cyd * w_s4_b2_lo;
            r_s4_xa_hi <= r_s3_cyd * w_s4_b2_hi;
            r_s4_xb_lo <= r_s3_byd * w_s4_c2_lo;
            r_s4_xb_hi <= r_s3_byd * w_s4_c2_hi;
            r_s4_ya_lo <= r_s3_bxd * w_s4_c2_lo;
            r_s4_ya_hi <= r_s3_bxd * w_s4_c2_hi;
            r_s4_yb_lo <= r_s3_cxd * w_s4_b2_lo;
            r_s4_yb_hi <= r_s3_cxd * w_s4_b2_hi;

            r_s5_ax <= r_s4_ax;
            r_s5_ay <= r_s4_ay;
            r_s5_d  <= r_s4_d;
            r_s5_nx <= n_s5_nx;
            r_s5_ny <= n_s5_ny;

            r_s6_ax   <= r_s5_ax;
            r_s6_ay   <= r_s5_ay;
            r_s6_numx <= n_s6_numx;
            r_s6_numy <= n_s6_numy;
            r_s6_den  <= n_s6_den;
            r_s6_negx <= r_s5_nx[NXW-1] ^ r_s5_d[DW-1];
            r_s6_negy <= r_s5_ny[NXW-1] ^ r_s5_d[DW-1];
            r_s6_deg  <= (r_s5_d == '0);

            r_pa_ax  <= w_div[tc_pkg::DIV_CELLS].side.ax;
            r_pa_ay  <= w_div[tc_pkg::DIV_CELLS].side.ay;
            r_pa_deg <= w_div[tc_pkg::DIV_CELLS].side.deg;
            r_pa_mqx <= n_pa_mqx;
            r_pa_mqy <= n_pa_mqy;
            r_pa_ux  <= w_div[tc_pkg::DIV_CELLS].side.negx ? -$signed({1'b0, n_pa_mqx})
                                                            : $signed({1'b0, n_pa_mqx});
            r_pa_uy  <= w_div[tc_pkg::DIV_CELLS].side.negy ? -$signed({1'b0, n_pa_mqy})
                                                            : $signed({1'b0, n_pa_mqy});

            r_pb_ox  <= n_pb_ox;
            r_pb_oy  <= n_pb_oy;
            r_pb_ovf <= n_pb_ovf;
            r_pb_deg <= r_pa_deg;
            r_pb_sqx <= r_pa_mqx * r_pa_mqx;
            r_pb_sqy <= r_pa_mqy * r_pa_mqy;

            r_out <= n_out;
        end
    end

    // ================= divider chain
    assign w_div[0] = r_s7;

    genvar g;
    generate
        for (g = 0; g < tc_pkg::DIV_CELLS; g++) begin : g_div
            tc_div_cell #(.SHIFT(tc_pkg::DIV_CELLS - 1 - g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_stage (w_div[g]),
                .o_stage (w_div[g+1])
            );
        end
    endgenerate

    // Clamp quotient magnitude at 2^33.
    always_comb begin
        n_pa_mqx = (w_div[tc_pkg::DIV_CELLS].side.hix
                    || w_div[tc_pkg::DIV_CELLS].qx > {1'b0, tc_pkg::UCLAMP})
                   ? tc_pkg::UCLAMP : w_div[tc_pkg::DIV_CELLS].qx[MQW-1:0];
        n_pa_mqy = (w_div[tc_pkg::DIV_CELLS].side.hiy
                    || w_div[tc_pkg::DIV_CELLS].qy > {1'b0, tc_pkg::UCLAMP})
                   ? tc_pkg::UCLAMP : w_div[tc_pkg::DIV_CELLS].qy[MQW-1:0];
    end

    // Center = A + u, saturated to 32 bits.
    always_comb begin
        w_pb_sx  = {{4{r_pa_ax[CW-1]}}, r_pa_ax} + {r_pa_ux[UW-1], r_pa_ux};
        w_pb_sy  = {{4{r_pa_ay[CW-1]}}, r_pa_ay} + {r_pa_uy[UW-1], r_pa_uy};
        n_pb_ovf = 1'b0;
        n_pb_ox  = w_pb_sx[CW-1:0];
        n_pb_oy  = w_pb_sy[CW-1:0];
        if (w_pb_sx[CW+3:CW-1] != '0 && w_pb_sx[CW+3:CW-1] != '1) begin
            n_pb_ovf = 1'b1;
            n_pb_ox  = w_pb_sx[CW+3] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        if (w_pb_sy[CW+3:CW-1] != '0 && w_pb_sy[CW+3:CW-1] != '1) begin
            n_pb_ovf = 1'b1;
            n_pb_oy  = w_pb_sy[CW+3] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_comb begin
        n_pc          = '0;
        n_pc.valid    = r_pb_valid;
        n_pc.rem      = r_pb_sqx + r_pb_sqy;
        n_pc.side.ox  = r_pb_ox;
        n_pc.side.oy  = r_pb_oy;
        n_pc.side.ovf = r_pb_ovf;
        n_pc.side.deg = r_pb_deg;
    end

    // ================= square root chain
    assign w_sq[0] = r_pc;

    generate
        for (g = 0; g < tc_pkg::SQRT_CELLS; g++) begin : g_sqrt
            tc_sqrt_cell #(.SHIFT(tc_pkg::SQRT_CELLS - 1 - g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_stage (w_sq[g]),
                .o_stage (w_sq[g+1])
            );
        end
    endgenerate

    // Round to nearest: bump the floor root when remainder exceeds it.
    assign w_last = w_sq[tc_pkg::SQRT_CELLS];
    assign w_up   = w_last.rem > {{(SW-RW){1'b0}}, w_last.root};
    assign w_rnd  = {1'b0, w_last.root} + {{RW{1'b0}}, w_up};

    always_comb begin
        n_out            = '0;
        if (w_last.side.deg) begin
            n_out.degenerate = 1'b1;
        end else begin
            n_out.center_x = w_last.side.ox;
            n_out.center_y = w_last.side.oy;
            n_out.overflow = w_last.side.ovf;
            if (w_rnd[RW:CW] != '0) begin
                n_out.radius   = '1;
                n_out.overflow = 1'b1;
            end else begin
                n_out.radius = w_rnd[CW-1:0];
            end
        end
    end

    assign o_circ.valid = r_out_valid;
    assign o_circ.data  = r_out;

    `TC_ASSERT_IMP(a_degen_zero, o_circ.valid && o_circ.data.degenerate, o_circ.data.center_x == 0 && o_circ.data.center_y == 0 && o_circ.data.radius == 0 && !o_circ.data.overflow, "degenerate item has nonzero fields")
    `TC_ASSERT_NXT(a_degen_pass, w_en && w_last.valid && w_last.side.deg, o_circ.valid && o_circ.data.degenerate, "degenerate flag lost at output")

endmodule
